@@ rtl/core/ais_pkg.sv @@
// ----------------------------------------------------------------------------
// ais_pkg
// Shared widths, register indexes and stage records for the analog input
// scaling pipeline.
// ----------------------------------------------------------------------------
package ais_pkg;
    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int WIDE        = VALUE_WIDTH + 1;     // span / difference width
    localparam int FW          = FRAC_BITS + 1;       // fraction 0..ONE
    localparam int SQ_BITS     = 2 * FRAC_BITS + 2;   // radicand width
    localparam int IDX_WIDTH   = 3;

    localparam logic [IDX_WIDTH-1:0] REG_RAW_LOW   = 3'd0;
    localparam logic [IDX_WIDTH-1:0] REG_RAW_HIGH  = 3'd1;
    localparam logic [IDX_WIDTH-1:0] REG_EU_LOW    = 3'd2;
    localparam logic [IDX_WIDTH-1:0] REG_EU_HIGH   = 3'd3;
    localparam logic [IDX_WIDTH-1:0] REG_ROOT_MODE = 3'd4;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] raw_low;
        logic signed [VALUE_WIDTH-1:0] raw_high;
        logic signed [VALUE_WIDTH-1:0] eu_low;
        logic signed [VALUE_WIDTH-1:0] eu_high;
        logic                          root_mode;
    } cfg_t;

    // Per-transaction control carried down the pipe
    typedef struct packed {
        logic                          zero_span;
        logic                          root_mode;
        logic signed [VALUE_WIDTH-1:0] eu_low;
        logic signed [WIDE-1:0]        eu_span;
    } ctl_t;
endpackage

@@ rtl/core/ais_div.sv @@
// ----------------------------------------------------------------------------
// ais_div
// Pipelined restoring divider: one quotient bit per stage, FRAC_BITS stages.
// ----------------------------------------------------------------------------
module ais_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              in_valid,
    input  logic [ais_pkg::WIDE-1:0]          in_rem,
    input  logic [ais_pkg::WIDE-1:0]          in_div,
    input  logic                              in_sat,
    input  ais_pkg::ctl_t                     in_ctl,
    output logic                              out_valid,
    output logic [ais_pkg::FW-1:0]            out_q,
    output ais_pkg::ctl_t                     out_ctl
);
    import ais_pkg::*;

    logic [WIDE:0]      rem_reg  [FRAC_BITS+1];
    logic [WIDE-1:0]    div_reg  [FRAC_BITS+1];
    logic [FRAC_BITS-1:0] q_reg  [FRAC_BITS+1];
    logic               sat_reg  [FRAC_BITS+1];
    ctl_t               ctl_reg  [FRAC_BITS+1];
    logic [FRAC_BITS:0] vld_reg;

    always_comb
    begin
        rem_reg[0] = {1'b0, in_rem};
        div_reg[0] = in_div;
        q_reg[0]   = '0;
        sat_reg[0] = in_sat;
        ctl_reg[0] = in_ctl;
        vld_reg[0] = in_valid;
    end

    for (genvar i = 0; i < FRAC_BITS; i++) begin : g_st
        logic [WIDE:0] sh;
        logic          ge;
        assign sh = {rem_reg[i][WIDE-1:0], 1'b0};
        assign ge = sh >= {1'b0, div_reg[i]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i+1] <= 1'b0;
            else if (adv)
                vld_reg[i+1] <= vld_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i+1] <= ge ? sh - {1'b0, div_reg[i]} : sh;
                q_reg[i+1]   <= {q_reg[i][FRAC_BITS-2:0], ge};
                div_reg[i+1] <= div_reg[i];
                sat_reg[i+1] <= sat_reg[i];
                ctl_reg[i+1] <= ctl_reg[i];
            end
        end
    end

    assign out_valid = vld_reg[FRAC_BITS];
    assign out_q     = sat_reg[FRAC_BITS] ? FW'(1) << FRAC_BITS
                                          : {1'b0, q_reg[FRAC_BITS]};
    assign out_ctl   = ctl_reg[FRAC_BITS];
endmodule

@@ rtl/core/ais_sqrt.sv @@
// ----------------------------------------------------------------------------
// ais_sqrt
// Pipelined integer square root, one result bit per stage; bypass in linear
// mode.
// ----------------------------------------------------------------------------
module ais_sqrt (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      in_valid,
    input  logic [ais_pkg::FW-1:0]    in_frac,
    input  ais_pkg::ctl_t             in_ctl,
    output logic                      out_valid,
    output logic [ais_pkg::FW-1:0]    out_frac,
    output ais_pkg::ctl_t             out_ctl
);
    import ais_pkg::*;

    localparam int NS = SQ_BITS / 2;

    logic [SQ_BITS-1:0] v_reg   [NS+1];
    logic [SQ_BITS-1:0] res_reg [NS+1];
    logic [FW-1:0]      lin_reg [NS+1];
    ctl_t               ctl_reg [NS+1];
    logic [NS:0]        vld_reg;

    always_comb
    begin
        v_reg[0]   = SQ_BITS'(in_frac) << FRAC_BITS;
        res_reg[0] = '0;
        lin_reg[0] = in_frac;
        ctl_reg[0] = in_ctl;
        vld_reg[0] = in_valid;
    end

    for (genvar i = 0; i < NS; i++) begin : g_st
        localparam logic [SQ_BITS-1:0] BIT = SQ_BITS'(1) << (SQ_BITS - 2 - 2 * i);
        logic [SQ_BITS-1:0] trial;
        logic               ge;
        assign trial = res_reg[i] + BIT;
        assign ge    = v_reg[i] >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i+1] <= 1'b0;
            else if (adv)
                vld_reg[i+1] <= vld_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                v_reg[i+1]   <= ge ? v_reg[i] - trial : v_reg[i];
                res_reg[i+1] <= ge ? (res_reg[i] >> 1) + BIT : res_reg[i] >> 1;
                lin_reg[i+1] <= lin_reg[i];
                ctl_reg[i+1] <= ctl_reg[i];
            end
        end
    end

    assign out_valid = vld_reg[NS];
    assign out_frac  = ctl_reg[NS].root_mode ? res_reg[NS][FW-1:0] : lin_reg[NS];
    assign out_ctl   = ctl_reg[NS];
endmodule

@@ rtl/core/analog_input_scaling_sqrt.sv @@
// ----------------------------------------------------------------------------
// analog_input_scaling_sqrt
// Stages: 2 prep, 16 divide, 17 root, 4 scale; throughput one transaction per
// cycle unless the output stalls, set by the bit-per-stage divider and root pipes.
// Reset: registers return to 4..20 mA into 0..100.0 linear; pipe emptied.
// The whole pipe advances when the output register is empty or taken.
// ----------------------------------------------------------------------------
module analog_input_scaling_sqrt (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_we,
    input  logic [ais_pkg::IDX_WIDTH-1:0]            cfg_index,
    input  logic [ais_pkg::VALUE_WIDTH-1:0]          cfg_data,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic signed [ais_pkg::VALUE_WIDTH-1:0]   raw_sample,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic signed [ais_pkg::VALUE_WIDTH-1:0]   eng_value
);
    import ais_pkg::*;

    cfg_t cfg_reg;
    logic adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.raw_low   <= VALUE_WIDTH'(262144);
            cfg_reg.raw_high  <= VALUE_WIDTH'(1310720);
            cfg_reg.eu_low    <= '0;
            cfg_reg.eu_high   <= VALUE_WIDTH'(6553600);
            cfg_reg.root_mode <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RAW_LOW:   cfg_reg.raw_low   <= cfg_data;
                REG_RAW_HIGH:  cfg_reg.raw_high  <= cfg_data;
                REG_EU_LOW:    cfg_reg.eu_low    <= cfg_data;
                REG_EU_HIGH:   cfg_reg.eu_high   <= cfg_data;
                REG_ROOT_MODE: cfg_reg.root_mode <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // Global advance: output slot free or being drained.
    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    // ---- Stage 1: clamp in root mode, spans
    logic signed [VALUE_WIDTH-1:0] x1;
    logic signed [VALUE_WIDTH-1:0] xc;
    logic signed [WIDE-1:0]        rspan_reg, x_reg;
    ctl_t                          ctl1_reg;
    logic                          v1_reg;

    always_comb
    begin
        x1 = raw_sample;
        if (cfg_reg.root_mode)
        begin
            if (x1 < cfg_reg.raw_low)
                x1 = cfg_reg.raw_low;
            if (x1 > cfg_reg.raw_high)
                x1 = cfg_reg.raw_high;
        end
        xc = x1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rspan_reg          <= WIDE'(cfg_reg.raw_high) - WIDE'(cfg_reg.raw_low);
            x_reg              <= WIDE'(xc) - WIDE'(cfg_reg.raw_low);
            ctl1_reg.zero_span <= cfg_reg.raw_high == cfg_reg.raw_low;
            ctl1_reg.root_mode <= cfg_reg.root_mode;
            ctl1_reg.eu_low    <= cfg_reg.eu_low;
            ctl1_reg.eu_span   <= WIDE'(cfg_reg.eu_high) - WIDE'(cfg_reg.eu_low);
        end
    end

    // ---- Stage 2: magnitudes, sign test, saturation
    logic [WIDE-1:0] dmag, smag;
    logic [WIDE-1:0] rem2_reg, div2_reg;
    logic            sat2_reg, zero2_reg, v2_reg;
    ctl_t            ctl2_reg;

    assign dmag = x_reg[WIDE-1] ? WIDE'(-x_reg) : WIDE'(x_reg);
    assign smag = rspan_reg[WIDE-1] ? WIDE'(-rspan_reg) : WIDE'(rspan_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            zero2_reg <= x_reg == '0 || (x_reg[WIDE-1] != rspan_reg[WIDE-1]);
            sat2_reg  <= dmag >= smag;
            rem2_reg  <= dmag;
            div2_reg  <= smag;
            ctl2_reg  <= ctl1_reg;
        end
    end

    // zero fraction: feed a zero remainder, no saturation
    logic            dv;
    logic [FW-1:0]   dq;
    ctl_t            dctl;

    ais_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v2_reg),
        .in_rem    (zero2_reg ? '0 : rem2_reg),
        .in_div    (div2_reg),
        .in_sat    (sat2_reg && !zero2_reg),
        .in_ctl    (ctl2_reg),
        .out_valid (dv),
        .out_q     (dq),
        .out_ctl   (dctl)
    );

    logic            sv;
    logic [FW-1:0]   sfrac;
    ctl_t            sctl;

    ais_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (dv),
        .in_frac   (dq),
        .in_ctl    (dctl),
        .out_valid (sv),
        .out_frac  (sfrac),
        .out_ctl   (sctl)
    );

    // ---- Scale: split |eu_span| into high and low halves, two products
    localparam int HW = WIDE - FRAC_BITS;
    logic [WIDE-1:0]           emag;
    logic [HW-1:0]             h_reg;
    logic [FRAC_BITS-1:0]      l_reg;
    logic [FW-1:0]             f_reg;
    ctl_t                      ctl3_reg;
    logic                      v3_reg;

    assign emag = sctl.eu_span[WIDE-1] ? WIDE'(-sctl.eu_span) : WIDE'(sctl.eu_span);

    logic [HW+FW-1:0]          hp_reg;
    logic [FRAC_BITS+FW-1:0]   lp_reg;
    ctl_t                      ctl4_reg;
    logic                      v4_reg;

    logic [HW+FW-1:0]          prod;
    logic [HW+FW-1:0]          prod_reg;
    ctl_t                      ctl5_reg;
    logic                      v5_reg;

    logic [FRAC_BITS+FW-1:0]   lr;
    assign lr   = ctl4_reg.eu_span[WIDE-1] ? lp_reg + (FRAC_BITS+FW)'((1 << FRAC_BITS) - 1)
                                           : lp_reg;
    assign prod = hp_reg + (HW+FW)'(lr >> FRAC_BITS);

    logic signed [VALUE_WIDTH-1:0] res;
    assign res = ctl5_reg.zero_span ? ctl5_reg.eu_low :
                 ctl5_reg.eu_span[WIDE-1]
                     ? VALUE_WIDTH'(ctl5_reg.eu_low - prod_reg[VALUE_WIDTH-1:0])
                     : VALUE_WIDTH'(ctl5_reg.eu_low + prod_reg[VALUE_WIDTH-1:0]);

    logic signed [VALUE_WIDTH-1:0] eng_value_reg;
    logic                          out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v3_reg        <= sv;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            out_valid_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h_reg         <= emag[WIDE-1:FRAC_BITS];
            l_reg         <= emag[FRAC_BITS-1:0];
            f_reg         <= sfrac;
            ctl3_reg      <= sctl;
            hp_reg        <= h_reg * f_reg;
            lp_reg        <= l_reg * f_reg;
            ctl4_reg      <= ctl3_reg;
            prod_reg      <= prod;
            ctl5_reg      <= ctl4_reg;
            eng_value_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign eng_value = eng_value_reg;
endmodule

@@ test/analog_input_scaling_sqrt_test.sv @@
// ----------------------------------------------------------------------------
// analog_input_scaling_sqrt_test
// Self-checking bench for the analog input scaling block: an internal
// predictor computes each expected engineering value from the raw sample and
// the current range settings; results are compared in order under random
// sender idling and receiver stalls, over linear and square-root settings.
// ----------------------------------------------------------------------------
module analog_input_scaling_sqrt_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ais_pkg::*;

    localparam int LATENCY     = 39;
    localparam int STALL_LIMIT = 20000;

    // index past the register list
    localparam logic [IDX_WIDTH-1:0] REG_SPARE = 3'd7;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [IDX_WIDTH-1:0]          cfg_index;
    logic [VALUE_WIDTH-1:0]        cfg_data;
    logic                          in_valid;
    logic                          in_stall;
    logic signed [VALUE_WIDTH-1:0] raw_sample;
    logic                          out_valid;
    logic                          out_stall;
    logic signed [VALUE_WIDTH-1:0] eng_value;

    analog_input_scaling_sqrt u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .raw_sample (raw_sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .eng_value  (eng_value)
    );

    // Predictor copy of the range settings
    logic signed [VALUE_WIDTH-1:0] set_raw_low  = 32'sd262144;
    logic signed [VALUE_WIDTH-1:0] set_raw_high = 32'sd1310720;
    logic signed [VALUE_WIDTH-1:0] set_eu_low   = 32'sd0;
    logic signed [VALUE_WIDTH-1:0] set_eu_high  = 32'sd6553600;
    logic                          set_root     = 1'b0;

    logic signed [VALUE_WIDTH-1:0] expected_eu[$];
    int  errors;
    int  sent;
    int  checked;
    int  quiet_cycles;
    int  send_idle_pct;
    int  stall_pct;
    bit  done;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // floor(sqrt(v)) by bit pairs
    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned res;
        longint unsigned bit_w;
        res   = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v)
            bit_w >>= 2;
        while (bit_w != 0)
        begin
            if (v >= res + bit_w)
            begin
                v   -= res + bit_w;
                res  = (res >> 1) + bit_w;
            end
            else
                res >>= 1;
            bit_w >>= 2;
        end
        return res;
    endfunction

    // Expected engineering value for one raw sample under current settings
    function automatic logic signed [VALUE_WIDTH-1:0] scaled_value(
        logic signed [VALUE_WIDTH-1:0] sample);
        longint          x;
        longint          span;
        longint          diff;
        longint          eu_span;
        longint          num;
        longint          offs;
        longint unsigned frac;
        longint unsigned dm;
        longint unsigned sm;
        x    = sample;
        span = longint'(set_raw_high) - longint'(set_raw_low);
        if (span == 0)
            return set_eu_low;
        if (set_root)
        begin
            if (x < set_raw_low)
                x = set_raw_low;
            if (x > set_raw_high)
                x = set_raw_high;
        end
        diff = x - longint'(set_raw_low);
        if (diff == 0 || ((diff < 0) != (span < 0)))
            frac = 0;
        else
        begin
            dm = (diff < 0) ? -diff : diff;
            sm = (span < 0) ? -span : span;
            frac = (dm >= sm) ? (64'd1 << FRAC_BITS) : (dm << FRAC_BITS) / sm;
        end
        if (set_root)
            frac = int_root(frac << FRAC_BITS);
        eu_span = longint'(set_eu_high) - longint'(set_eu_low);
        // |eu_span| < 2^33, frac <= 2^16: product fits in 64 bits
        num = longint'(frac) * eu_span;
        offs = num >>> FRAC_BITS;   // arithmetic shift floors
        return VALUE_WIDTH'(longint'(set_eu_low) + offs);
    endfunction

    // Output side: random stalls, in-order compare
    always @(negedge clk)
        if (rst_n)
            out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_eu.size() == 0)
            begin
                $error("eng_value: unexpected transaction, actual %0d", eng_value);
                errors++;
            end
            else
            begin
                if (eng_value !== expected_eu[0])
                begin
                    $error("eng_value: expected %0d actual %0d", expected_eu[0], eng_value);
                    errors++;
                end
                void'(expected_eu.pop_front());
                checked++;
            end
        end
    end

    // Watchdog on cycles with no accepted transaction
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // One sample; prediction taken at acceptance. Valid stays high after
    // acceptance so back-to-back samples need no gap; idling or drain drops it.
    task automatic send_sample(logic signed [VALUE_WIDTH-1:0] s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        raw_sample <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_eu.push_back(scaled_value(s));
        sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_eu.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    // Only called with the pipe empty
    task automatic write_reg(logic [IDX_WIDTH-1:0] idx, logic [VALUE_WIDTH-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_RAW_LOW:   set_raw_low  = val;
            REG_RAW_HIGH:  set_raw_high = val;
            REG_EU_LOW:    set_eu_low   = val;
            REG_EU_HIGH:   set_eu_high  = val;
            REG_ROOT_MODE: set_root     = val[0];
            default: ;
        endcase
    endtask

    task automatic set_ranges(logic [31:0] rl, logic [31:0] rh, logic [31:0] el,
                              logic [31:0] eh, logic rm);
        drain();
        write_reg(REG_RAW_LOW, rl);
        write_reg(REG_RAW_HIGH, rh);
        write_reg(REG_EU_LOW, el);
        write_reg(REG_EU_HIGH, eh);
        write_reg(REG_ROOT_MODE, {31'($urandom), rm});   // upper bits ignored
    endtask

    function automatic logic [31:0] rand_edge();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($urandom_range(2097152));
            3: return -32'($urandom_range(2097152));
            default: return $urandom;
        endcase
    endfunction

    // Samples around and beyond the raw span, plus noise
    function automatic logic [31:0] rand_sample();
        longint lo;
        longint hi;
        lo = set_raw_low;
        hi = set_raw_high;
        case ($urandom_range(9))
            0: return $urandom;
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            3: return set_raw_low;
            4: return set_raw_high;
            default: return 32'(lo + longint'((hi - lo) * longint'($urandom_range(1200))
                                / 1000) - (hi - lo) / 10);
        endcase
    endfunction

    task automatic test_reset_defaults();
        logic [31:0] pts[$];
        pts = '{32'h8000_0000, 32'h7fff_ffff, 0, 262144, 262145, 786432, 1310719,
                1310720, 1310721, 32'hffff_ffff};
        foreach (pts[i])
            send_sample(pts[i]);
    endtask

    task automatic test_special_ranges();
        // zero raw span
        set_ranges(1000, 1000, 32'hffff_0000, 500, 0);
        send_sample(1000); send_sample(32'h8000_0000);
        // extreme spans, inverted engineering span, root mode
        set_ranges(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1);
        send_sample(32'h8000_0000); send_sample(0); send_sample(32'h7fff_ffff);
        // inverted raw span, both modes
        set_ranges(1310720, 262144, 0, 6553600, 1);
        send_sample(0); send_sample(786432); send_sample(2000000);
        set_ranges(1310720, 262144, 32'h8000_0000, 32'h7fff_ffff, 0);
        send_sample(0); send_sample(786432); send_sample(2000000);
        // index beyond the register list is ignored
        drain();
        write_reg(REG_SPARE, 32'hdead_beef);
        send_sample(600000);
    endtask

    task automatic test_random_traffic(int n);
        int per_phase;
        per_phase = n / 12;
        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 66; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 66; end
                default: begin send_idle_pct = 13; stall_pct = 13; end
            endcase
            if ($urandom_range(2) == 0)
                set_ranges(rand_edge(), rand_edge(), rand_edge(), rand_edge(),
                           $urandom_range(1));
            else
                set_ranges($urandom_range(262144), 32'($urandom_range(4000000)) + 300000,
                           rand_edge(), rand_edge(), ph[0]);
            for (int i = 0; i < per_phase; i++)
                send_sample(rand_sample());
        end
    endtask

    initial
    begin
        errors        = 0;
        sent          = 0;
        checked       = 0;
        quiet_cycles  = 0;
        done          = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        raw_sample    = '0;
        out_stall     = 1'b0;
        rst_n         = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_special_ranges();
        test_random_traffic(1440);

        drain();
        done = 1;
        $display("covered %0d samples, %0d results checked, linear and root modes,",
                 sent, checked);
        $display("zero, inverted and extreme spans, with idle and stall phases");
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
